>>> hdl/frm_pkg.sv
// Shared types and constants for the focus ring manager.
// Used by frm_link_mem, frm_ctrl and focus_ring_manager; depends on nothing.
`default_nettype none

package frm_pkg;

  // Number of jobs that can join the ring, and the width of a job index.
  localparam int JOBS  = 64;
  localparam int JOB_W = $clog2(JOBS);

  // Operation codes carried by the cmd field of a request.
  typedef enum logic [1:0] {
    CMD_REQUEST = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_SWITCH  = 2'd2,
    CMD_FORCE   = 2'd3
  } cmd_e;

  typedef logic [JOB_W-1:0] job_t;

  // Access bundle from the controller to the link memories.
  typedef struct packed {
    logic rd_en;
    job_t rd_addr;
    logic nxt_we;
    job_t nxt_addr;
    job_t nxt_data;
    logic prv_we;
    job_t prv_addr;
    job_t prv_data;
  } link_req_t;

endpackage : frm_pkg

`default_nettype wire

>>> hdl/frm_link_mem.sv
// Next and previous link memories of the focus ring, one synchronous write
// and one registered read each. Depends on frm_pkg.
`default_nettype none

module frm_link_mem (
  input  wire logic              clk_i,
  input  wire frm_pkg::link_req_t req_i,
  output frm_pkg::job_t          nxt_rdata_o,
  output frm_pkg::job_t          prv_rdata_o
);

  frm_pkg::job_t nxt_mem [frm_pkg::JOBS];
  frm_pkg::job_t prv_mem [frm_pkg::JOBS];

  // Next links: write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (req_i.nxt_we) begin
      nxt_mem[req_i.nxt_addr] <= req_i.nxt_data;
    end
    if (req_i.rd_en) begin
      nxt_rdata_o <= nxt_mem[req_i.rd_addr];
    end
  end

  // Previous links: same organization.
  always_ff @(posedge clk_i) begin
    if (req_i.prv_we) begin
      prv_mem[req_i.prv_addr] <= req_i.prv_data;
    end
    if (req_i.rd_en) begin
      prv_rdata_o <= prv_mem[req_i.rd_addr];
    end
  end

endmodule : frm_link_mem

`default_nettype wire

>>> hdl/frm_ctrl.sv
// Sequencer of the focus ring manager: membership bitmap, focus head and the
// read-modify-write steps on the link memories. Depends on frm_pkg.
`default_nettype none

module frm_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [1:0]        cmd_i,
  input  wire frm_pkg::job_t     job_i,
  output frm_pkg::link_req_t     mem_req_o,
  input  wire frm_pkg::job_t     nxt_rdata_i,
  input  wire frm_pkg::job_t     prv_rdata_i,
  output logic                   done_o,
  output logic                   focus_valid_o,
  output frm_pkg::job_t          focus_job_o,
  output logic                   focus_changed_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD   = 2'd1;
  localparam logic [1:0] ST_WR2  = 2'd2;

  logic [1:0]                 state_q, state_d;
  frm_pkg::cmd_e              cmd_q;
  frm_pkg::job_t              job_q;
  logic                       v0_q;
  frm_pkg::job_t              h0_q;
  frm_pkg::job_t              tail_q, tail_d;
  frm_pkg::job_t              head_q, head_d;
  logic                       nonempty_q, nonempty_d;
  logic [frm_pkg::JOBS-1:0]   member_q, member_d;
  logic                       done_q, done_d;
  logic                       fv_q, fv_d;
  frm_pkg::job_t              fj_q, fj_d;
  logic                       fc_q, fc_d;
  logic                       accept;
  logic                       is_member;

  assign accept    = start && (state_q == ST_IDLE);
  assign busy      = (state_q != ST_IDLE);
  assign is_member = member_q[job_q];

  // Step logic: issue the link read on accept, then update links and head.
  always_comb begin
    state_d    = state_q;
    tail_d     = tail_q;
    head_d     = head_q;
    nonempty_d = nonempty_q;
    member_d   = member_q;
    done_d     = 1'b0;
    mem_req_o  = '0;

    // A release reads the links of the job; every other command reads the head's.
    mem_req_o.rd_en   = accept;
    mem_req_o.rd_addr = (cmd_i == frm_pkg::CMD_RELEASE) ? job_i : head_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_RD;
        end
      end

      ST_RD: begin
        state_d = ST_IDLE;
        done_d  = 1'b1;
        case (cmd_q)
          frm_pkg::CMD_REQUEST, frm_pkg::CMD_FORCE: begin
            if (!is_member) begin
              member_d[job_q]    = 1'b1;
              mem_req_o.nxt_we   = 1'b1;
              mem_req_o.nxt_addr = job_q;
              mem_req_o.prv_we   = 1'b1;
              mem_req_o.prv_addr = job_q;
              if (!nonempty_q) begin
                // Sole member links to itself and takes the head.
                mem_req_o.nxt_data = job_q;
                mem_req_o.prv_data = job_q;
                head_d             = job_q;
                nonempty_d         = 1'b1;
              end else begin
                // Link in between the tail and the head; finish next cycle.
                mem_req_o.nxt_data = head_q;
                mem_req_o.prv_data = prv_rdata_i;
                tail_d             = prv_rdata_i;
                state_d            = ST_WR2;
                done_d             = 1'b0;
              end
            end
            if (cmd_q == frm_pkg::CMD_FORCE) begin
              head_d = job_q;
            end
          end

          frm_pkg::CMD_RELEASE: begin
            if (is_member) begin
              member_d[job_q] = 1'b0;
              if (nxt_rdata_i != job_q) begin
                mem_req_o.prv_we   = 1'b1;
                mem_req_o.prv_addr = nxt_rdata_i;
                mem_req_o.prv_data = prv_rdata_i;
                mem_req_o.nxt_we   = 1'b1;
                mem_req_o.nxt_addr = prv_rdata_i;
                mem_req_o.nxt_data = nxt_rdata_i;
                if (job_q == head_q) begin
                  head_d = nxt_rdata_i;
                end
              end else begin
                // The last member leaves: the ring is empty.
                nonempty_d = 1'b0;
                head_d     = '0;
              end
            end
          end

          frm_pkg::CMD_SWITCH: begin
            if (nonempty_q) begin
              head_d = nxt_rdata_i;
            end
          end

          default: begin
          end
        endcase
      end

      ST_WR2: begin
        // Close the ring: old tail points to the job, old head back to it.
        mem_req_o.nxt_we   = 1'b1;
        mem_req_o.nxt_addr = tail_q;
        mem_req_o.nxt_data = job_q;
        mem_req_o.prv_we   = 1'b1;
        mem_req_o.prv_addr = h0_q;
        mem_req_o.prv_data = job_q;
        state_d            = ST_IDLE;
        done_d             = 1'b1;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Result as seen after this step.
    fv_d = nonempty_d;
    fj_d = nonempty_d ? head_d : '0;
    fc_d = (fv_d != v0_q) || (fj_d != h0_q);
  end

  // Control state and ring registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      head_q     <= '0;
      nonempty_q <= 1'b0;
      member_q   <= '0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      head_q     <= head_d;
      nonempty_q <= nonempty_d;
      member_q   <= member_d;
      done_q     <= done_d;
    end
  end

  // Request payload, old focus snapshot and result registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= frm_pkg::cmd_e'(cmd_i);
      job_q <= job_i;
      v0_q  <= nonempty_q;
      h0_q  <= nonempty_q ? head_q : '0;
    end
    tail_q <= tail_d;
    if (done_d) begin
      fv_q <= fv_d;
      fj_q <= fj_d;
      fc_q <= fc_d;
    end
  end

  assign done_o          = done_q;
  assign focus_valid_o   = fv_q;
  assign focus_job_o     = fj_q;
  assign focus_changed_o = fc_q;

endmodule : frm_ctrl

`default_nettype wire

>>> hdl/focus_ring_manager.sv
// Channel   | Direction | Signals                                    | Handshake
// request   | in        | cmd_i, job_i                               | start high, busy low
// result    | out       | focus_valid_o, focus_job_o, focus_changed_o | done_o for one cycle
//
// After the accepting edge busy is high for the read of the links and one write pair, and
// also for a second write pair when a job is linked into a nonempty ring; the next request
// can be taken once busy is low again.
// The single write port of each link memory sets the count of write cycles.
// The result appears with done_o in the cycle after the last step, when busy is low.
// Reset empties the ring at once; the link memories need no clearing.
// The receiver cannot stall; done_o is never held.
//
// Top level of the focus ring manager. Depends on frm_pkg, frm_link_mem, frm_ctrl.
`default_nettype none

module focus_ring_manager (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  cmd_i,
  input  wire logic [5:0]  job_i,
  output logic             done_o,
  output logic             focus_valid_o,
  output logic [5:0]       focus_job_o,
  output logic             focus_changed_o
);

  frm_pkg::link_req_t mem_req;
  frm_pkg::job_t      nxt_rdata;
  frm_pkg::job_t      prv_rdata;

  // Sequencer with bitmap and head.
  frm_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .cmd_i           (cmd_i),
    .job_i           (job_i),
    .mem_req_o       (mem_req),
    .nxt_rdata_i     (nxt_rdata),
    .prv_rdata_i     (prv_rdata),
    .done_o          (done_o),
    .focus_valid_o   (focus_valid_o),
    .focus_job_o     (focus_job_o),
    .focus_changed_o (focus_changed_o)
  );

  // Link memories.
  frm_link_mem u_link_mem (
    .clk_i       (clk_i),
    .req_i       (mem_req),
    .nxt_rdata_o (nxt_rdata),
    .prv_rdata_o (prv_rdata)
  );

  // A result only comes once the sequencer is free again.
  a_done_not_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  // An accepted request always occupies the sequencer in the next cycle.
  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && !done_o))
    else $error("accepted request did not occupy the sequencer");

  // An empty ring reports job zero.
  a_empty_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !focus_valid_o) |-> (focus_job_o == '0))
    else $error("empty ring reported a nonzero job");

endmodule : focus_ring_manager

`default_nettype wire

>>> tb/sv/focus_ring_manager_tb.sv
// Self-checking testbench for focus_ring_manager: directed and random focus requests are
// checked against an in-bench model of the job ring and its focus head.
// Depends on frm_pkg and the focus_ring_manager RTL.
`default_nettype none

module focus_ring_manager_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import frm_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 8;

  // Focus report of one request, as the block should return it.
  typedef struct {
    logic valid;
    job_t job;
    logic changed;
  } focus_report_t;

  logic       clk_i;
  logic       rst_ni;
  logic       start;
  logic       busy;
  logic [1:0] cmd_i;
  logic [5:0] job_i;
  logic       done_o;
  logic       focus_valid_o;
  logic [5:0] focus_job_o;
  logic       focus_changed_o;

  // Ring model: membership, links, head and member count.
  bit   ring_member [JOBS];
  job_t ring_next   [JOBS];
  job_t ring_prev   [JOBS];
  job_t ring_head;
  bit   ring_live;
  int   ring_size;

  focus_report_t focus_expected[$];
  int            mismatch_count;
  int            stall_cycles;
  int            sender_idle_pct;

  focus_ring_manager u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cmd_i          (cmd_i),
    .job_i          (job_i),
    .done_o         (done_o),
    .focus_valid_o  (focus_valid_o),
    .focus_job_o    (focus_job_o),
    .focus_changed_o(focus_changed_o)
  );

  // Clock with a 4 ns period.
  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // Link a new job in just before the head, or make it the sole member.
  function automatic void ring_link(job_t j);
    job_t tail;
    if (ring_member[j]) return;
    if (!ring_live) begin
      ring_head = j;
      ring_next[j] = j;
      ring_prev[j] = j;
      ring_live = 1'b1;
    end else begin
      tail = ring_prev[ring_head];
      ring_prev[j] = tail;
      ring_next[j] = ring_head;
      ring_next[tail] = j;
      ring_prev[ring_head] = j;
    end
    ring_member[j] = 1'b1;
    ring_size++;
  endfunction

  // Move the head one step round the ring.
  function automatic void ring_advance();
    job_t nxt;
    if (!ring_live) return;
    nxt = ring_next[ring_head];
    if (nxt != ring_head) ring_head = nxt;
  endfunction

  // Unlink a member; a member holding focus hands it on first.
  function automatic void ring_unlink(job_t j);
    job_t nxt;
    job_t prv;
    if (!ring_member[j]) return;
    ring_member[j] = 1'b0;
    ring_size--;
    if (ring_live && j == ring_head) ring_advance();
    nxt = ring_next[j];
    if (nxt != j) begin
      prv = ring_prev[j];
      ring_prev[nxt] = prv;
      ring_next[prv] = nxt;
    end else begin
      ring_live = 1'b0;
      ring_head = '0;
    end
  endfunction

  // Apply one request to the ring model and report the focus that follows.
  function automatic focus_report_t predict_focus(cmd_e c, job_t j);
    focus_report_t rep;
    logic          live_was;
    job_t          head_was;
    live_was = ring_live;
    head_was = ring_live ? ring_head : '0;
    case (c)
      CMD_REQUEST: ring_link(j);
      CMD_RELEASE: ring_unlink(j);
      CMD_SWITCH:  ring_advance();
      default: begin
        ring_link(j);
        if (ring_member[j]) ring_head = j;
      end
    endcase
    rep.valid   = ring_live;
    rep.job     = ring_live ? ring_head : '0;
    rep.changed = (live_was != rep.valid) || (head_was != rep.job);
    return rep;
  endfunction

  // Pick one current member at random; the ring must not be empty.
  function automatic job_t pick_member();
    job_t pool[$];
    for (int i = 0; i < JOBS; i++) begin
      if (ring_member[i]) pool.push_back(job_t'(i));
    end
    return pool[$urandom_range(pool.size() - 1)];
  endfunction

  // Offer one request, wait until the block has taken it and is no longer busy, then record its expected report.
  task automatic send_request(input cmd_e c, input job_t j);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    cmd_i <= c;
    job_i <= j;
    @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
    focus_expected.push_back(predict_focus(c, j));
  endtask

  // Compare each report with the oldest expectation.
  always @(posedge clk_i) begin
    focus_report_t exp_rep;
    if (rst_ni && done_o === 1'b1) begin
      if (focus_expected.size() == 0) begin
        $error("done_o: no request outstanding, focus_job_o %0d", focus_job_o);
        mismatch_count++;
      end else begin
        exp_rep = focus_expected.pop_front();
        if (focus_valid_o !== exp_rep.valid) begin
          $error("focus_valid: expected %0d, actual %0d", exp_rep.valid, focus_valid_o);
          mismatch_count++;
        end
        if (focus_job_o !== exp_rep.job) begin
          $error("focus_job: expected %0d, actual %0d", exp_rep.job, focus_job_o);
          mismatch_count++;
        end
        if (focus_changed_o !== exp_rep.changed) begin
          $error("focus_changed: expected %0d, actual %0d", exp_rep.changed,
                 focus_changed_o);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk_i) begin
    if ((start === 1'b1 && busy === 1'b0) || done_o === 1'b1) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Empty-ring cases, every operation, and the corner cases of each.
  task automatic test_directed();
    send_request(CMD_SWITCH, 6'd0);    // switch with no members
    send_request(CMD_RELEASE, 6'd63);  // release of a non-member on an empty ring
    send_request(CMD_REQUEST, 6'd0);   // first member becomes head
    send_request(CMD_REQUEST, 6'd0);   // request of a member
    send_request(CMD_SWITCH, 6'd0);    // switch on a ring of one
    send_request(CMD_REQUEST, 6'd63);
    send_request(CMD_REQUEST, 6'd21);
    send_request(CMD_SWITCH, 6'd42);   // job ignored by switch
    send_request(CMD_FORCE, 6'd42);    // force of a new job
    send_request(CMD_FORCE, 6'd42);    // force of the current head
    send_request(CMD_FORCE, 6'd0);     // force of an existing member
    send_request(CMD_RELEASE, 6'd0);   // release of the job holding focus
    send_request(CMD_RELEASE, 6'd5);   // release of a non-member
    send_request(CMD_SWITCH, 6'd0);
    send_request(CMD_RELEASE, 6'd63);
    send_request(CMD_RELEASE, 6'd21);
    send_request(CMD_RELEASE, 6'd42);  // last member leaves
    send_request(CMD_FORCE, 6'd63);    // force on an empty ring
    send_request(CMD_SWITCH, 6'd0);
    send_request(CMD_RELEASE, 6'd63);
  endtask

  // Random mix; releases and forces mostly name current members.
  task automatic test_random_mix(input int count);
    cmd_e c;
    job_t j;
    repeat (count) begin
      c = cmd_e'($urandom_range(3));
      j = job_t'($urandom_range(JOBS - 1));
      if ((c == CMD_RELEASE || c == CMD_FORCE) && ring_size > 0 &&
          $urandom_range(99) < 70) begin
        j = pick_member();
      end
      send_request(c, j);
    end
  endtask

  // Empty the ring one member at a time with random switches between some releases, then refill it.
  task automatic test_drain_refill();
    while (ring_size > 0) begin
      if ($urandom_range(3) == 0) send_request(CMD_SWITCH, job_t'($urandom_range(JOBS - 1)));
      send_request(CMD_RELEASE, pick_member());
    end
    repeat (12) send_request(CMD_REQUEST, job_t'($urandom_range(JOBS - 1)));
  endtask

  initial begin
    rst_ni          = 1'b0;
    start           = 1'b0;
    cmd_i           = CMD_REQUEST;
    job_i           = '0;
    mismatch_count  = 0;
    stall_cycles    = 0;
    sender_idle_pct = 0;
    ring_head       = '0;
    ring_live       = 1'b0;
    ring_size       = 0;
    for (int i = 0; i < JOBS; i++) begin
      ring_member[i] = 1'b0;
      ring_next[i]   = '0;
      ring_prev[i]   = '0;
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_mix(110);
    test_drain_refill();

    // The result side cannot stall, so the later phases vary only the sender.
    sender_idle_pct = 68;
    test_random_mix(110);
    test_drain_refill();
    sender_idle_pct = 0;
    test_random_mix(90);
    sender_idle_pct = 24;
    test_random_mix(110);
    test_drain_refill();

    start <= 1'b0;
    while (focus_expected.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule : focus_ring_manager_tb

`default_nettype wire
